// ===== hdl/masked_image_convolution_macros.svh =====
// Assertion macros for the masked image convolution block.
`ifndef MASKED_IMAGE_CONVOLUTION_MACROS_SVH
`define MASKED_IMAGE_CONVOLUTION_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define MIC_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("implication failed in the same cycle");
// Check that a condition implies another in the next cycle.
`define MIC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("implication failed in the next cycle");
`else
`define MIC_ASSERT_SAME(label, clk, rst_n, lhs, rhs)
`define MIC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

// ===== hdl/mic_pkg.sv =====
package mic_pkg;

    typedef enum logic [1:0] {
        CMD_COEF  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_KERNEL_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_KERNEL_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_CENTER_COLUMN  = 3'd4;
    localparam logic [2:0] CFG_CENTER_ROW     = 3'd5;
    localparam logic [2:0] CFG_MASK_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_EDGE_BIT       = 3'd7;

    localparam int unsigned FIELD_W = 16;

endpackage

// ===== hdl/masked_image_convolution.sv =====
// Masked 2-D convolution with variance, one item at a time.
// Load and ignored items end after decoding; a pixel that answers nothing ends after the
// position compare. An answered interior pixel reads each tap in turn (one row store and one
// coefficient read per tap through the single read port); a border copy reads only its own
// pixel, and a flush skips the position compare. A stalled result waits in S_OUT.
// Reset (synchronous, active low) clears counters, control and configuration to defaults;
// the row and coefficient memories hold garbage until written.
module masked_image_convolution #(
    parameter int MAX_KERNEL         = 7,
    parameter int MAX_COLUMNS        = 2048,
    parameter int MAX_ROWS           = 2048,
    parameter int COEF_FRACTION_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [5:0]           i_coef_index,
    input  logic signed [15:0]   i_coef_value,
    input  logic signed [15:0]   i_pixel_value,
    input  logic [15:0]          i_pixel_variance,
    input  logic [15:0]          i_pixel_mask,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [15:0]   o_out_value,
    output logic [15:0]          o_out_variance,
    output logic [15:0]          o_out_mask,
    output logic                 o_is_border,
    output logic                 o_size_error,
    output logic                 o_last
);

    `include "masked_image_convolution_macros.svh"

    // widths derived from the parameters
    localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int KW     = $clog2(MAX_KERNEL + 1);            // holds kernel size
    localparam int RM_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW     = $clog2(MAX_COLUMNS);               // column index
    localparam int RW     = $clog2(MAX_ROWS);                  // row index
    localparam int WW     = $clog2(MAX_COLUMNS + 1);           // image width
    localparam int HW     = $clog2(MAX_ROWS + 1);              // image height
    localparam int LW     = ((HW > WW) ? HW : WW) + 2;         // position compares
    localparam int PW     = RW + WW + 1;                       // raster position
    localparam int AW     = $clog2(MAX_KERNEL * MAX_COLUMNS);  // row store address
    localparam int CA     = (TAPS > 1) ? $clog2(TAPS) : 1;     // coefficient address
    localparam int TB     = $clog2(TAPS + 1);
    localparam int VSUM_W = 32 + TB + 1;
    localparam int VAR_W  = 47 + TB;
    localparam int ENT_W  = 3 * mic_pkg::FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_CMP, S_BEGIN, S_BWAIT,
        S_TRD, S_TMUL, S_TMUL2, S_TACC, S_FIN, S_OUT
    } t_state;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [11:0]        r_cfg_w, r_cfg_h;
    logic [2:0]         r_cfg_kw, r_cfg_kh, r_cfg_cc, r_cfg_cr;
    logic signed [15:0] r_cfg_thr;
    logic signed [4:0]  r_cfg_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= 12'd2048;
            r_cfg_h   <= 12'd2048;
            r_cfg_kw  <= 3'd3;
            r_cfg_kh  <= 3'd3;
            r_cfg_cc  <= 3'd1;
            r_cfg_cr  <= 3'd1;
            r_cfg_thr <= '0;
            r_cfg_eb  <= -5'sd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mic_pkg::CFG_IMAGE_WIDTH:    r_cfg_w   <= i_cfg_data[11:0];
                mic_pkg::CFG_IMAGE_HEIGHT:   r_cfg_h   <= i_cfg_data[11:0];
                mic_pkg::CFG_KERNEL_WIDTH:   r_cfg_kw  <= i_cfg_data[2:0];
                mic_pkg::CFG_KERNEL_HEIGHT:  r_cfg_kh  <= i_cfg_data[2:0];
                mic_pkg::CFG_CENTER_COLUMN:  r_cfg_cc  <= i_cfg_data[2:0];
                mic_pkg::CFG_CENTER_ROW:     r_cfg_cr  <= i_cfg_data[2:0];
                mic_pkg::CFG_MASK_THRESHOLD: r_cfg_thr <= i_cfg_data;
                mic_pkg::CFG_EDGE_BIT:       r_cfg_eb  <= i_cfg_data[4:0];
                default:                     ;
            endcase
        end
    end

    // Clamp sizes into the supported range; pull the center inside the kernel.
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [KW-1:0] eff_kw, eff_kh, eff_cc, eff_cr;
    logic          size_err;

    always_comb begin
        eff_w  = (r_cfg_w == '0) ? WW'(1) :
                 ((r_cfg_w > MAX_COLUMNS) ? WW'(MAX_COLUMNS) : WW'(r_cfg_w));
        eff_h  = (r_cfg_h == '0) ? HW'(1) :
                 ((r_cfg_h > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(r_cfg_h));
        eff_kw = (r_cfg_kw == '0) ? KW'(1) :
                 ((r_cfg_kw > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_cfg_kw));
        eff_kh = (r_cfg_kh == '0) ? KW'(1) :
                 ((r_cfg_kh > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_cfg_kh));
        eff_cc = (r_cfg_cc < eff_kw) ? KW'(r_cfg_cc) : eff_kw - KW'(1);
        eff_cr = (r_cfg_cr < eff_kh) ? KW'(r_cfg_cr) : eff_kh - KW'(1);
        size_err = (LW'(eff_w) < LW'(eff_kw)) || (LW'(eff_h) < LW'(eff_kh));
    end

    // ---------------------------------------------------------------
    // control and datapath registers
    // ---------------------------------------------------------------
    t_state            r_state;
    logic [1:0]        r_cmd;
    logic              r_done;
    logic [CW-1:0]     r_icol, r_ocol;
    logic [RW-1:0]     r_irow, r_orow;
    logic [RM_W-1:0]   r_irm, r_orm;     // row modulo MAX_KERNEL
    logic [PW-1:0]     r_p;
    logic [PW:0]       r_qd;
    logic              r_int;
    logic [KW-1:0]     r_ti, r_tj;
    logic signed [31:0]        r_vprod;
    logic [30:0]               r_c2;
    logic [15:0]               r_tvar;
    logic [46:0]               r_varprod;
    logic signed [VSUM_W-1:0]  r_vsum;
    logic [VAR_W-1:0]          r_varsum;
    logic [15:0]               r_msum;
    logic signed [15:0]        r_res_value;
    logic [15:0]               r_res_var, r_res_mask;
    logic                      r_out_valid;

    // memories
    logic [ENT_W-1:0]   r_rs_mem [MAX_KERNEL * MAX_COLUMNS];
    logic [ENT_W-1:0]   r_rs_q;
    logic signed [15:0] r_cf_mem [TAPS];
    logic signed [15:0] r_cf_q;

    logic in_acc;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // write ports: pixel (while not done) or in-range coefficient written as the item is taken
    logic          rs_we, cf_we;
    logic [AW-1:0] rs_wa;
    always_comb begin
        rs_we = in_acc && (i_command == mic_pkg::CMD_PIXEL) && !r_done;
        cf_we = in_acc && (i_command == mic_pkg::CMD_COEF) && (i_coef_index < TAPS);
        rs_wa = AW'(AW'(r_irm) * AW'(MAX_COLUMNS) + AW'(r_icol));
    end

    // read address: own slot for a border copy, else the current tap
    logic [RM_W+1:0] tap_rs;
    logic [RM_W-1:0] tap_rm;
    logic [CW-1:0]   tap_col;
    logic [AW-1:0]   rs_ra;
    logic [CA-1:0]   cf_ra;
    always_comb begin
        tap_rs = (RM_W+2)'(r_orm) + (RM_W+2)'(r_ti) + (RM_W+2)'(MAX_KERNEL)
                 - (RM_W+2)'(eff_cr);
        if (tap_rs >= (RM_W+2)'(2 * MAX_KERNEL)) begin
            tap_rm = RM_W'(tap_rs - (RM_W+2)'(2 * MAX_KERNEL));
        end else if (tap_rs >= (RM_W+2)'(MAX_KERNEL)) begin
            tap_rm = RM_W'(tap_rs - (RM_W+2)'(MAX_KERNEL));
        end else begin
            tap_rm = RM_W'(tap_rs);
        end
        tap_col = r_ocol + CW'(r_tj) - CW'(eff_cc);
        if (r_state == S_BEGIN) begin
            rs_ra = AW'(AW'(r_orm) * AW'(MAX_COLUMNS) + AW'(r_ocol));
        end else begin
            rs_ra = AW'(AW'(tap_rm) * AW'(MAX_COLUMNS) + AW'(tap_col));
        end
        cf_ra = CA'(CA'(r_ti) * CA'(MAX_KERNEL) + CA'(r_tj));
    end

    // The sequencer never reads an entry in the cycle it is written.
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rs_mem[rs_wa] <= {i_pixel_value, i_pixel_variance, i_pixel_mask};
        end
        r_rs_q <= r_rs_mem[rs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cf_we) begin
            r_cf_mem[CA'(i_coef_index)] <= i_coef_value;
        end
        r_cf_q <= r_cf_mem[cf_ra];
    end

    // position compares
    logic interior, is_last, ocol_wrap, icol_wrap, irow_wrap;
    logic [KW-1:0] d_row, d_col;
    always_comb begin
        interior = !size_err
            && (LW'(r_orow) >= LW'(eff_cr))
            && (LW'(LW'(r_orow) + LW'(eff_kh) - LW'(1) - LW'(eff_cr)) < LW'(eff_h))
            && (LW'(r_ocol) >= LW'(eff_cc))
            && (LW'(LW'(r_ocol) + LW'(eff_kw) - LW'(1) - LW'(eff_cc)) < LW'(eff_w));
        is_last   = (LW'(r_orow) >= LW'(eff_h) - LW'(1))
                    && (LW'(r_ocol) >= LW'(eff_w) - LW'(1));
        ocol_wrap = (LW'(r_ocol) + LW'(1)) >= LW'(eff_w);
        icol_wrap = (LW'(r_icol) + LW'(1)) >= LW'(eff_w);
        irow_wrap = (LW'(r_irow) + LW'(1)) >= LW'(eff_h);
        d_row     = eff_kh - KW'(1) - eff_cr;
        d_col     = eff_kw - KW'(1) - eff_cc;
    end

    // tap data split
    logic signed [15:0] t_pv;
    logic [15:0]        t_var, t_mask;
    logic               last_tap;
    assign t_pv     = r_rs_q[ENT_W-1 -: 16];
    assign t_var    = r_rs_q[31:16];
    assign t_mask   = r_rs_q[15:0];
    assign last_tap = (r_tj == eff_kw - KW'(1)) && (r_ti == eff_kh - KW'(1));

    // floor shift and saturation of the sums
    logic signed [VSUM_W-1:0] vs_sh;
    logic [VAR_W-1:0]         var_sh;
    logic signed [15:0]       vs_sat;
    logic [15:0]              var_sat;
    always_comb begin
        vs_sh  = r_vsum >>> COEF_FRACTION_BITS;
        var_sh = r_varsum >> (2 * COEF_FRACTION_BITS);
        if (vs_sh > VSUM_W'(32767)) begin
            vs_sat = 16'sh7fff;
        end else if (vs_sh < -VSUM_W'(32768)) begin
            vs_sat = -16'sh8000;
        end else begin
            vs_sat = vs_sh[15:0];
        end
        var_sat = (var_sh > VAR_W'(65535)) ? 16'hffff : var_sh[15:0];
    end

    // edge bit for border copies
    logic [15:0] edge_mask;
    assign edge_mask = r_cfg_eb[4] ? 16'h0000 : (16'h0001 << r_cfg_eb[3:0]);

    // a finished result moves to the output register once that register is free
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_icol      <= '0;
            r_irow      <= '0;
            r_irm       <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_orm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, else drop the old one once the consumer takes it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_command;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_cmd == mic_pkg::CMD_PIXEL && !r_done) begin
                        // raster positions of the taken pixel and the next answer
                        r_p  <= PW'(PW'(r_irow) * PW'(eff_w) + PW'(r_icol));
                        r_qd <= size_err ? (PW+1)'(PW'(r_orow) * PW'(eff_w) + PW'(r_ocol))
                              : (PW+1)'(PW'(r_orow) * PW'(eff_w) + PW'(r_ocol))
                              + (PW+1)'(PW'(d_row) * PW'(eff_w) + PW'(d_col));
                        if (icol_wrap) begin
                            r_icol <= '0;
                            if (irow_wrap) begin
                                r_irow <= '0;
                                r_irm  <= '0;
                                r_done <= 1'b1;
                            end else begin
                                r_irow <= r_irow + RW'(1);
                                r_irm  <= (r_irm == RM_W'(MAX_KERNEL - 1)) ? '0
                                          : r_irm + RM_W'(1);
                            end
                        end else begin
                            r_icol <= r_icol + CW'(1);
                        end
                        r_state <= S_CMP;
                    end else if ((r_cmd == mic_pkg::CMD_PIXEL || r_cmd == mic_pkg::CMD_FLUSH)
                                 && r_done) begin
                        r_state <= S_BEGIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CMP: begin
                    r_state <= ((PW+1)'(r_p) >= r_qd) ? S_BEGIN : S_IDLE;
                end
                S_BEGIN: begin
                    r_int    <= interior;
                    r_ti     <= '0;
                    r_tj     <= '0;
                    r_vsum   <= '0;
                    r_varsum <= '0;
                    r_msum   <= '0;
                    r_state  <= interior ? S_TRD : S_BWAIT;
                end
                S_BWAIT: begin
                    // border copy of the own pixel
                    r_res_value <= t_pv;
                    r_res_var   <= t_var;
                    r_res_mask  <= t_mask | edge_mask;
                    r_state     <= S_OUT;
                end
                S_TRD: begin
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_vprod <= r_cf_q * t_pv;
                    r_c2    <= 31'(r_cf_q * r_cf_q);
                    r_tvar  <= t_var;
                    if (t_mask != '0 && r_cf_q > r_cfg_thr) begin
                        r_msum <= r_msum | t_mask;
                    end
                    r_state <= S_TMUL2;
                end
                S_TMUL2: begin
                    r_varprod <= r_c2 * r_tvar;
                    r_state   <= S_TACC;
                end
                S_TACC: begin
                    r_vsum   <= r_vsum + VSUM_W'(r_vprod);
                    r_varsum <= r_varsum + VAR_W'(r_varprod);
                    if (last_tap) begin
                        r_state <= S_FIN;
                    end else begin
                        if (r_tj == eff_kw - KW'(1)) begin
                            r_tj <= '0;
                            r_ti <= r_ti + KW'(1);
                        end else begin
                            r_tj <= r_tj + KW'(1);
                        end
                        r_state <= S_TRD;
                    end
                end
                S_FIN: begin
                    r_res_value <= vs_sat;
                    r_res_var   <= var_sat;
                    r_res_mask  <= r_msum;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        o_out_value    <= r_res_value;
                        o_out_variance <= r_res_var;
                        o_out_mask     <= r_res_mask;
                        o_is_border    <= !r_int;
                        o_size_error   <= size_err;
                        o_last         <= is_last;
                        if (is_last) begin
                            r_icol <= '0;
                            r_irow <= '0;
                            r_irm  <= '0;
                            r_ocol <= '0;
                            r_orow <= '0;
                            r_orm  <= '0;
                            r_done <= 1'b0;
                        end else if (ocol_wrap) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + RW'(1);
                            r_orm  <= (r_orm == RM_W'(MAX_KERNEL - 1)) ? '0
                                      : r_orm + RM_W'(1);
                        end else begin
                            r_ocol <= r_ocol + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `MIC_ASSERT_NEXT(a_take_blocks, i_clk, i_rst_n, in_acc, o_in_stall)
    `MIC_ASSERT_SAME(a_rise_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT))
    `MIC_ASSERT_SAME(a_tap_range, i_clk, i_rst_n, r_state == S_TACC, r_ti < eff_kh && r_tj < eff_kw)
    `MIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule
